[rtl/bplimf_pkg.sv]
// shared types, constants and the root table of the broken power-law imf unit
`default_nettype none
package bplimf_pkg;

	localparam int MASS_FB = 24;
	localparam int LOG_FB = 27;
	localparam int EXP_FB = 28;
	localparam int VAL_W = 48;
	localparam int DIV_W = VAL_W + EXP_FB;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [VAL_W-1:0] VMAX = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] ONE_Q32 = 48'h0001_0000_0000;
	localparam logic [31:0] INV_LN10 = 32'd1865280596;
	localparam logic [31:0] DRAW_SPLIT = 32'd3267211687;
	localparam logic [33:0] DRAW_K1 = 34'd7725361541;
	localparam logic [33:0] DRAW_K2 = 34'd4296015268;
	localparam logic [31:0] DRAW_D1 = 32'd3621142762;
	localparam logic [31:0] DRAW_D2 = 32'd417824297;
	localparam logic signed [33:0] DRAW_E1 = -34'sd894784853;
	localparam logic signed [33:0] DRAW_E2 = -34'sd206488812;
	localparam logic signed [33:0] EXP_BUMP = 34'sd268435456;

	localparam logic [1:0] OP_DENSITY = 2'd0;
	localparam logic [1:0] OP_COUNT = 2'd1;
	localparam logic [1:0] OP_MASS = 2'd2;
	localparam logic [1:0] OP_DRAW = 2'd3;

	localparam logic [2:0] REG_LOW_LIMIT = 3'd0;
	localparam logic [2:0] REG_BREAK = 3'd1;
	localparam logic [2:0] REG_UPPER_LIMIT = 3'd2;
	localparam logic [2:0] REG_LOW_NORM = 3'd3;
	localparam logic [2:0] REG_HIGH_NORM = 3'd4;
	localparam logic [2:0] REG_LOW_SLOPE = 3'd5;
	localparam logic [2:0] REG_HIGH_SLOPE = 3'd6;

	typedef enum logic [1:0] {JOB_ZERO, JOB_DENS, JOB_CUM, JOB_DRAW} job_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SETUP, ST_TERM, ST_PNORM, ST_PLOG, ST_PMUL, ST_PEXP, ST_PSCALE,
		ST_PRET, ST_DIFF, ST_MHI, ST_MLO, ST_MRET, ST_DIV, ST_DRET, ST_ACC, ST_FINISH
	} st_t;

	typedef enum logic [3:0] {
		RET_DENS, RET_DRAW, RET_PH, RET_PL, RET_MDENS, RET_M1, RET_M2, RET_DTERM, RET_DDRAW
	} ret_t;

	typedef struct packed {
		logic [31:0] low_mass_limit;
		logic [31:0] break_mass;
		logic [31:0] upper_mass_limit;
		logic [31:0] low_segment_norm;
		logic [31:0] high_segment_norm;
		logic [31:0] low_segment_slope;
		logic [31:0] high_segment_slope;
	} cfg_t;

	typedef struct packed {
		job_t job;
		logic seg_low;
		logic bump;
		logic two_terms;
		logic [31:0] mass;
		logic [31:0] lo_mass;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef logic [31:0] root_tab_t [EXP_FB];

	// r_i = isqrt(r_(i-1) << 31), r_0 = 2.0 in q1.31
	function automatic root_tab_t build_roots();
		root_tab_t t;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bitv;
		r = 64'h1_0000_0000;
		for (int i = 0; i < EXP_FB; i++) begin
			x = r << 31;
			res = '0;
			bitv = 64'h4000_0000_0000_0000;
			for (int j = 0; j < 32; j++) begin
				if (bitv > x) bitv = bitv >> 2;
			end
			for (int j = 0; j < 32; j++) begin
				if (bitv != 0) begin
					if (x >= res + bitv) begin
						x = x - (res + bitv);
						res = (res >> 1) + bitv;
					end else begin
						res = res >> 1;
					end
					bitv = bitv >> 2;
				end
			end
			r = res;
			t[i] = r[31:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOTS = build_roots();

endpackage
`default_nettype wire

[rtl/bplimf_front.sv]
// front end: classifies an incoming item into a job descriptor
`default_nettype none
module bplimf_front (
	input  wire logic [1:0]          operation,
	input  wire logic [31:0]         star_mass,
	input  wire logic [31:0]         uniform_draw,
	input  wire bplimf_pkg::cfg_t    cfg,
	output bplimf_pkg::desc_t        desc
);

	logic above_upper, above_break, above_low;

	assign above_upper = star_mass > cfg.upper_mass_limit;
	assign above_break = star_mass > cfg.break_mass;
	assign above_low = star_mass > cfg.low_mass_limit;

	always_comb begin
		desc.job = bplimf_pkg::JOB_ZERO;
		desc.seg_low = 1'b0;
		desc.bump = 1'b0;
		desc.two_terms = 1'b0;
		desc.mass = star_mass;
		desc.lo_mass = above_low ? star_mass : cfg.low_mass_limit;
		case (operation)
			bplimf_pkg::OP_DENSITY: begin
				if (!above_upper && (above_break || above_low)) begin
					desc.job = bplimf_pkg::JOB_DENS;
					desc.seg_low = !above_break;
				end
			end
			bplimf_pkg::OP_COUNT, bplimf_pkg::OP_MASS: begin
				if (!above_upper) begin
					desc.job = bplimf_pkg::JOB_CUM;
					desc.bump = (operation == bplimf_pkg::OP_MASS);
					desc.two_terms = !above_break;
				end
			end
			bplimf_pkg::OP_DRAW: begin
				desc.job = bplimf_pkg::JOB_DRAW;
				desc.seg_low = uniform_draw < bplimf_pkg::DRAW_SPLIT;
				desc.mass = uniform_draw;
			end
			default: begin
				desc.job = bplimf_pkg::JOB_ZERO;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/bplimf_fifo.sv]
// job queue between the front end and the evaluation engine
`default_nettype none
module bplimf_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire bplimf_pkg::desc_t     din,
	input  wire logic                  pop,
	output bplimf_pkg::desc_t          dout,
	output bplimf_pkg::fifo_stat_t     stat
);

	bplimf_pkg::desc_t slot_q [bplimf_pkg::QDEPTH];
	logic [bplimf_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [bplimf_pkg::QPTR_W:0] count_q;

	assign stat.full = (count_q == (bplimf_pkg::QPTR_W+1)'(bplimf_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign dout = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[rtl/bplimf_back.sv]
// evaluation engine: power, multiply and divide sequencer on one shared multiplier
`default_nettype none
module bplimf_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bplimf_pkg::cfg_t       cfg,
	input  wire bplimf_pkg::desc_t      head,
	input  wire bplimf_pkg::fifo_stat_t fstat,
	output logic                        pop,
	output logic                        done,
	output logic [47:0]                 result_value,
	output logic                        saturated
);

	bplimf_pkg::st_t state_q, state_d;
	bplimf_pkg::ret_t ret_q;
	bplimf_pkg::desc_t job_q;
	logic term_q, sat_q, neg_q;
	logic [31:0] pm_q;
	logic signed [33:0] pe_q;
	logic [31:0] y_q;
	logic [26:0] frac_q;
	logic signed [6:0] lgi_q;
	logic [6:0] cnt_q;
	logic signed [10:0] pn_q;
	logic [27:0] pf_q;
	logic [31:0] acc_q;
	logic [47:0] pres_q, ph_q;
	logic [47:0] ma_q;
	logic [31:0] mb_q;
	logic msh32_q;
	logic [63:0] mt_q;
	logic [47:0] v_q;
	logic [75:0] dv_q;
	logic [31:0] dr_q, dd_q;
	logic signed [50:0] total_q;
	logic done_q, sat_out_q;
	logic [47:0] val_out_q;

	// term selection
	logic signed [33:0] bump, t_b, dens_b;
	logic [31:0] t_a, t_hi, t_lo, t_bmag;

	assign bump = job_q.bump ? bplimf_pkg::EXP_BUMP : 34'sd0;
	assign t_b = term_q ? (34'(signed'(cfg.low_segment_slope)) + bump)
		: (34'(signed'(cfg.high_segment_slope)) + bump);
	assign t_a = term_q ? cfg.low_segment_norm : cfg.high_segment_norm;
	assign t_hi = term_q ? cfg.break_mass : cfg.upper_mass_limit;
	assign t_lo = term_q ? job_q.lo_mass : (job_q.two_terms ? cfg.break_mass : job_q.mass);
	assign t_bmag = t_b[33] ? 32'(-t_b) : 32'(t_b);
	assign dens_b = 34'(signed'(job_q.seg_low ? cfg.low_segment_slope
		: cfg.high_segment_slope));

	// normalisation
	logic [4:0] msb_pos;
	always_comb begin
		msb_pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (pm_q[i]) msb_pos = 5'(i);
		end
	end

	// log magnitude and exponent magnitude
	logic signed [33:0] lg_s;
	logic lg_neg, e_neg;
	logic [31:0] lmag, emag;
	assign lg_s = {lgi_q, frac_q};
	assign lg_neg = lgi_q[6];
	assign lmag = lg_neg ? 32'(-lg_s) : 32'(lg_s);
	assign e_neg = pe_q[33];
	assign emag = e_neg ? 32'(-pe_q) : 32'(pe_q);

	// shared multiplier
	logic [31:0] mx, my;
	logic [63:0] prod;
	always_comb begin
		mx = '0;
		my = '0;
		case (state_q)
			bplimf_pkg::ST_PLOG: begin
				mx = y_q;
				my = y_q;
			end
			bplimf_pkg::ST_PMUL: begin
				mx = lmag;
				my = emag;
			end
			bplimf_pkg::ST_PEXP: begin
				mx = acc_q;
				my = bplimf_pkg::ROOTS[cnt_q[4:0]];
			end
			bplimf_pkg::ST_MHI: begin
				mx = msh32_q ? 32'(ma_q >> 32) : 32'(ma_q >> bplimf_pkg::MASS_FB);
				my = mb_q;
			end
			bplimf_pkg::ST_MLO: begin
				mx = msh32_q ? ma_q[31:0] : 32'(ma_q[bplimf_pkg::MASS_FB-1:0]);
				my = mb_q;
			end
			default: begin
				mx = '0;
			end
		endcase
	end
	assign prod = {32'b0, mx} * {32'b0, my};

	// log step
	logic [32:0] sq;
	assign sq = prod[63:31];

	// exponent split
	logic [36:0] pr;
	logic [27:0] pr_f;
	logic [8:0] pr_n;
	logic pr_neg, pr_fz;
	logic signed [10:0] n_new;
	logic [27:0] f_new;
	assign pr = prod[63:27];
	assign pr_f = pr[27:0];
	assign pr_n = pr[36:28];
	assign pr_fz = (pr_f == '0);
	assign pr_neg = (pr != '0) && (lg_neg != e_neg);
	always_comb begin
		n_new = 11'(signed'({2'b0, pr_n}));
		f_new = pr_f;
		if (pr_neg) begin
			n_new = -n_new - (pr_fz ? 11'sd0 : 11'sd1);
			f_new = pr_fz ? pr_f : 28'(29'h1000_0000 - {1'b0, pr_f});
		end
	end
	logic [4:0] fbit_idx;
	assign fbit_idx = 5'(bplimf_pkg::EXP_FB - 1) - cnt_q[4:0];

	// final scaling of 2^f
	logic signed [11:0] s_val, ns_val;
	logic [48:0] up_val;
	logic up_sat;
	assign s_val = 12'(pn_q) + 12'sd1;
	assign ns_val = -s_val;
	assign up_val = 49'(acc_q) << s_val[4:0];
	assign up_sat = (s_val > 12'sd16) || (up_val > 49'(bplimf_pkg::VMAX));

	// multiply low part
	logic [64:0] mlo_sum;
	assign mlo_sum = {1'b0, mt_q} + (msh32_q ? 65'(prod >> 32)
		: 65'(prod >> bplimf_pkg::MASS_FB));

	// divide step
	logic [32:0] rs;
	logic ge;
	assign rs = {dr_q, dv_q[75]};
	assign ge = rs >= {1'b0, dd_q};

	// term difference
	logic signed [48:0] diff;
	logic [47:0] mag;
	assign diff = $signed({1'b0, ph_q}) - $signed({1'b0, pres_q});
	assign mag = diff[48] ? 48'(-diff) : diff[47:0];

	// draw base
	logic [33:0] kmu;
	logic [31:0] base;
	logic q_hi_term;
	assign kmu = (job_q.seg_low ? bplimf_pkg::DRAW_K1 : bplimf_pkg::DRAW_K2) - {2'b0, job_q.mass};
	assign base = (dv_q[75:32] != '0) ? 32'hFFFF_FFFF : dv_q[31:0];
	assign q_hi_term = (dv_q[75:48] != '0);

	// result selection
	logic [47:0] fin_val;
	logic fin_sat;
	always_comb begin
		fin_val = '0;
		fin_sat = 1'b0;
		if (sat_q) begin
			fin_val = bplimf_pkg::VMAX;
			fin_sat = 1'b1;
		end else begin
			case (job_q.job)
				bplimf_pkg::JOB_DENS: fin_val = v_q;
				bplimf_pkg::JOB_DRAW: fin_val = pres_q;
				bplimf_pkg::JOB_CUM: begin
					if (total_q[50]) begin
						fin_sat = 1'b1;
					end else if (total_q[49:48] != '0) begin
						fin_val = bplimf_pkg::VMAX;
						fin_sat = 1'b1;
					end else begin
						fin_val = total_q[47:0];
					end
				end
				default: fin_val = '0;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			bplimf_pkg::ST_IDLE: begin
				if (!fstat.empty) begin
					pop = 1'b1;
					state_d = bplimf_pkg::ST_SETUP;
				end
			end
			bplimf_pkg::ST_SETUP: begin
				case (job_q.job)
					bplimf_pkg::JOB_DENS: state_d = bplimf_pkg::ST_PNORM;
					bplimf_pkg::JOB_DRAW: state_d = bplimf_pkg::ST_DIV;
					bplimf_pkg::JOB_CUM: state_d = bplimf_pkg::ST_TERM;
					default: state_d = bplimf_pkg::ST_FINISH;
				endcase
			end
			bplimf_pkg::ST_TERM: begin
				state_d = (t_b == 34'sd0) ? bplimf_pkg::ST_FINISH : bplimf_pkg::ST_PNORM;
			end
			bplimf_pkg::ST_PNORM: begin
				state_d = (pm_q == '0) ? bplimf_pkg::ST_PRET : bplimf_pkg::ST_PLOG;
			end
			bplimf_pkg::ST_PLOG: begin
				if (cnt_q == 7'(bplimf_pkg::LOG_FB - 1)) state_d = bplimf_pkg::ST_PMUL;
			end
			bplimf_pkg::ST_PMUL: state_d = bplimf_pkg::ST_PEXP;
			bplimf_pkg::ST_PEXP: begin
				if (cnt_q == 7'(bplimf_pkg::EXP_FB - 1)) state_d = bplimf_pkg::ST_PSCALE;
			end
			bplimf_pkg::ST_PSCALE: state_d = bplimf_pkg::ST_PRET;
			bplimf_pkg::ST_PRET: begin
				if (sat_q) begin
					state_d = bplimf_pkg::ST_FINISH;
				end else begin
					case (ret_q)
						bplimf_pkg::RET_DENS: state_d = bplimf_pkg::ST_MHI;
						bplimf_pkg::RET_PH: state_d = bplimf_pkg::ST_PNORM;
						bplimf_pkg::RET_PL: state_d = bplimf_pkg::ST_DIFF;
						default: state_d = bplimf_pkg::ST_FINISH;
					endcase
				end
			end
			bplimf_pkg::ST_DIFF: state_d = bplimf_pkg::ST_MHI;
			bplimf_pkg::ST_MHI: state_d = bplimf_pkg::ST_MLO;
			bplimf_pkg::ST_MLO: state_d = bplimf_pkg::ST_MRET;
			bplimf_pkg::ST_MRET: begin
				if (sat_q) begin
					state_d = bplimf_pkg::ST_FINISH;
				end else begin
					case (ret_q)
						bplimf_pkg::RET_M1: state_d = bplimf_pkg::ST_MHI;
						bplimf_pkg::RET_M2: state_d = bplimf_pkg::ST_DIV;
						default: state_d = bplimf_pkg::ST_FINISH;
					endcase
				end
			end
			bplimf_pkg::ST_DIV: begin
				if (cnt_q == 7'(bplimf_pkg::DIV_W - 1)) state_d = bplimf_pkg::ST_DRET;
			end
			bplimf_pkg::ST_DRET: begin
				case (ret_q)
					bplimf_pkg::RET_DTERM: begin
						state_d = q_hi_term ? bplimf_pkg::ST_FINISH : bplimf_pkg::ST_ACC;
					end
					bplimf_pkg::RET_DDRAW: state_d = bplimf_pkg::ST_PNORM;
					default: state_d = bplimf_pkg::ST_FINISH;
				endcase
			end
			bplimf_pkg::ST_ACC: begin
				state_d = (job_q.two_terms && !term_q) ? bplimf_pkg::ST_TERM
					: bplimf_pkg::ST_FINISH;
			end
			bplimf_pkg::ST_FINISH: state_d = bplimf_pkg::ST_IDLE;
			default: state_d = bplimf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bplimf_pkg::ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == bplimf_pkg::ST_FINISH);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			bplimf_pkg::ST_IDLE: begin
				if (!fstat.empty) begin
					job_q <= head;
					sat_q <= 1'b0;
				end
			end
			bplimf_pkg::ST_SETUP: begin
				case (job_q.job)
					bplimf_pkg::JOB_DENS: begin
						pm_q <= job_q.mass;
						pe_q <= dens_b;
						ret_q <= bplimf_pkg::RET_DENS;
					end
					bplimf_pkg::JOB_DRAW: begin
						dv_q <= bplimf_pkg::DIV_W'(kmu) << bplimf_pkg::MASS_FB;
						dd_q <= job_q.seg_low ? bplimf_pkg::DRAW_D1 : bplimf_pkg::DRAW_D2;
						dr_q <= '0;
						cnt_q <= '0;
						ret_q <= bplimf_pkg::RET_DDRAW;
					end
					bplimf_pkg::JOB_CUM: begin
						total_q <= '0;
						term_q <= 1'b0;
					end
					default: begin
						sat_q <= 1'b0;
					end
				endcase
			end
			bplimf_pkg::ST_TERM: begin
				if (t_b == 34'sd0) begin
					sat_q <= 1'b1;
				end else begin
					pm_q <= t_hi;
					pe_q <= t_b;
					ret_q <= bplimf_pkg::RET_PH;
				end
			end
			bplimf_pkg::ST_PNORM: begin
				if (pm_q == '0) begin
					// zero raised to a power
					if (pe_q > 34'sd0) begin
						pres_q <= '0;
					end else if (pe_q == 34'sd0) begin
						pres_q <= bplimf_pkg::ONE_Q32;
					end else begin
						pres_q <= bplimf_pkg::VMAX;
						sat_q <= 1'b1;
					end
				end else begin
					y_q <= pm_q << (5'd31 - msb_pos);
					lgi_q <= 7'(signed'({2'b0, msb_pos})) - 7'(bplimf_pkg::MASS_FB);
					frac_q <= '0;
					cnt_q <= '0;
				end
			end
			bplimf_pkg::ST_PLOG: begin
				if (sq[32]) begin
					y_q <= sq[32:1];
					frac_q <= {frac_q[25:0], 1'b1};
				end else begin
					y_q <= sq[31:0];
					frac_q <= {frac_q[25:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
			end
			bplimf_pkg::ST_PMUL: begin
				pn_q <= n_new;
				pf_q <= f_new;
				acc_q <= 32'h8000_0000;
				cnt_q <= '0;
			end
			bplimf_pkg::ST_PEXP: begin
				if (pf_q[fbit_idx]) acc_q <= prod[62:31];
				cnt_q <= cnt_q + 7'd1;
			end
			bplimf_pkg::ST_PSCALE: begin
				if (!s_val[11]) begin
					if (up_sat) begin
						pres_q <= bplimf_pkg::VMAX;
						sat_q <= 1'b1;
					end else begin
						pres_q <= up_val[47:0];
					end
				end else if (ns_val >= 12'sd32) begin
					pres_q <= '0;
				end else begin
					pres_q <= 48'(acc_q >> ns_val[4:0]);
				end
			end
			bplimf_pkg::ST_PRET: begin
				if (!sat_q) begin
					case (ret_q)
						bplimf_pkg::RET_DENS: begin
							ma_q <= pres_q;
							mb_q <= job_q.seg_low ? cfg.low_segment_norm : cfg.high_segment_norm;
							msh32_q <= 1'b0;
							ret_q <= bplimf_pkg::RET_MDENS;
						end
						bplimf_pkg::RET_PH: begin
							ph_q <= pres_q;
							pm_q <= t_lo;
							pe_q <= t_b;
							ret_q <= bplimf_pkg::RET_PL;
						end
						default: begin
							ph_q <= ph_q;
						end
					endcase
				end
			end
			bplimf_pkg::ST_DIFF: begin
				neg_q <= diff[48] != t_b[33];
				ma_q <= mag;
				mb_q <= t_a;
				msh32_q <= 1'b0;
				ret_q <= bplimf_pkg::RET_M1;
			end
			bplimf_pkg::ST_MHI: begin
				mt_q <= prod;
			end
			bplimf_pkg::ST_MLO: begin
				if (mlo_sum > 65'(bplimf_pkg::VMAX)) sat_q <= 1'b1;
				v_q <= mlo_sum[47:0];
			end
			bplimf_pkg::ST_MRET: begin
				if (!sat_q) begin
					case (ret_q)
						bplimf_pkg::RET_M1: begin
							ma_q <= v_q;
							mb_q <= bplimf_pkg::INV_LN10;
							msh32_q <= 1'b1;
							ret_q <= bplimf_pkg::RET_M2;
						end
						bplimf_pkg::RET_M2: begin
							dv_q <= bplimf_pkg::DIV_W'(v_q) << bplimf_pkg::EXP_FB;
							dd_q <= t_bmag;
							dr_q <= '0;
							cnt_q <= '0;
							ret_q <= bplimf_pkg::RET_DTERM;
						end
						default: begin
							ma_q <= ma_q;
						end
					endcase
				end
			end
			bplimf_pkg::ST_DIV: begin
				// restoring division, one quotient bit a cycle
				dr_q <= ge ? 32'(rs - {1'b0, dd_q}) : rs[31:0];
				dv_q <= {dv_q[74:0], ge};
				cnt_q <= cnt_q + 7'd1;
			end
			bplimf_pkg::ST_DRET: begin
				case (ret_q)
					bplimf_pkg::RET_DTERM: begin
						if (q_hi_term) sat_q <= 1'b1;
						else v_q <= dv_q[47:0];
					end
					bplimf_pkg::RET_DDRAW: begin
						pm_q <= base;
						pe_q <= job_q.seg_low ? bplimf_pkg::DRAW_E1 : bplimf_pkg::DRAW_E2;
						ret_q <= bplimf_pkg::RET_DRAW;
					end
					default: begin
						v_q <= v_q;
					end
				endcase
			end
			bplimf_pkg::ST_ACC: begin
				total_q <= neg_q ? total_q - $signed({3'b0, v_q})
					: total_q + $signed({3'b0, v_q});
				term_q <= 1'b1;
			end
			bplimf_pkg::ST_FINISH: begin
				val_out_q <= fin_val;
				sat_out_q <= fin_sat;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign done = done_q;
	assign result_value = val_out_q;
	assign saturated = sat_out_q;

endmodule
`default_nettype wire

[rtl/broken_power_law_imf_unit.sv]
// Broken power-law IMF unit: density, cumulative count, cumulative mass and inverse-CDF draw.
// An item is taken when start is high and busy low; up to four items wait in a job queue
// while the evaluation engine works on one at a time. The engine is built from the bit-serial
// log2 (27 steps) and the 2^f product (28 steps), both on one shared 32x32 multiplier, and
// the 76-step divider. Each result shows on result_value and saturated with done high for
// one cycle and cannot be held off. Configuration writes are always accepted (cfg_ready is
// tied high).
`default_nettype none
module broken_power_law_imf_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] star_mass,
	input  wire logic [31:0] uniform_draw,
	output logic             done,
	output logic [47:0]      result_value,
	output logic             saturated,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	bplimf_pkg::cfg_t cfg_q;
	bplimf_pkg::desc_t desc, head;
	bplimf_pkg::fifo_stat_t fstat;
	logic push, pop;

	assign cfg_ready = 1'b1;
	assign busy = fstat.full;
	assign push = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_mass_limit <= 32'd1342177;
			cfg_q.break_mass <= 32'd8388608;
			cfg_q.upper_mass_limit <= 32'd1677721600;
			cfg_q.low_segment_norm <= '0;
			cfg_q.high_segment_norm <= '0;
			cfg_q.low_segment_slope <= 32'hFB33_3333;
			cfg_q.high_segment_slope <= 32'hEB33_3333;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bplimf_pkg::REG_LOW_LIMIT: cfg_q.low_mass_limit <= cfg_data;
				bplimf_pkg::REG_BREAK: cfg_q.break_mass <= cfg_data;
				bplimf_pkg::REG_UPPER_LIMIT: cfg_q.upper_mass_limit <= cfg_data;
				bplimf_pkg::REG_LOW_NORM: cfg_q.low_segment_norm <= cfg_data;
				bplimf_pkg::REG_HIGH_NORM: cfg_q.high_segment_norm <= cfg_data;
				bplimf_pkg::REG_LOW_SLOPE: cfg_q.low_segment_slope <= cfg_data;
				bplimf_pkg::REG_HIGH_SLOPE: cfg_q.high_segment_slope <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bplimf_front u_front (
		.operation    (operation),
		.star_mass    (star_mass),
		.uniform_draw (uniform_draw),
		.cfg          (cfg_q),
		.desc         (desc)
	);

	bplimf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (desc),
		.pop    (pop),
		.dout   (head),
		.stat   (fstat)
	);

	bplimf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.fstat        (fstat),
		.pop          (pop),
		.done         (done),
		.result_value (result_value),
		.saturated    (saturated)
	);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> (result_value == bplimf_pkg::VMAX || result_value == '0))
		else $error("saturated result with a value other than full scale or zero");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fstat.empty)
		else $error("engine took a job from an empty queue");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !fstat.empty)
		else $error("accepted transaction missing from the queue");

endmodule
`default_nettype wire
